>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules.
// Each macro takes a label, the clock, the reset, antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Frame layout constants, state codes and result field widths for the
// serial frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int HEADER_LEN  = 10;
  localparam int LENGTH_POS  = 1;
  localparam int MAX_PAYLOAD = 512;

  // Offsets run over the header plus the largest payload.
  localparam int OFF_W = $clog2(HEADER_LEN + MAX_PAYLOAD + 1);
  localparam int LEN_W = 32;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ENDPOINT = 3'd1;
  localparam logic [2:0] ST_HEADER   = 3'd2;
  localparam logic [2:0] ST_PAYLOAD  = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_READY    = 3'd5;
  localparam logic [2:0] ST_ERROR    = 3'd6;

  localparam logic [1:0] Q_READY    = 2'd0;
  localparam logic [1:0] Q_ERROR    = 2'd1;
  localparam logic [1:0] Q_NOTREADY = 2'd2;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Result word layout, lowest bit first.
  localparam int RES_BITS = 3 + 2 + 1 + 1 + 10 + 8 + 8 + 10;
  localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> rtl/core/serial_frame_receiver_xor.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_xor
// Length-prefixed serial frame receiver with an XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_axis channel, one per transfer; tuser set to one
//   turns the transfer into a clear that returns the receiver to idle.
//   Every input transfer produces exactly one result transfer on m_axis,
//   carrying the state, query code, wake flag, the streamed header or
//   payload byte with its offset, the endpoint and the decoded length.
//   The user must set the start byte through the cfg channel while the block is idle; this is not enforced.
//   The result is valid in the cycle after its input transfer, and one item
//   is taken every cycle unless results stall; the frame state is updated by
//   a single pass of logic between the input handshake and the result register.
//   When the result side stalls, the result register holds its contents and
//   s_axis_tready drops until that result is taken; a new input is taken in
//   the same cycle as the waiting result leaves.
//   Reset clears the frame state, the start byte and the result valid flag;
//   both channels are held not ready while rst is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_xor
  import sfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,  // data_byte
  input  wire logic             s_axis_tuser,  // kind
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // status, query_code, wake, byte_valid, byte_offset, byte_value,
  // endpoint, payload_length, zero fill
  output logic [RES_W-1:0]      m_axis_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data
);

  logic [7:0]       open_code;
  logic [2:0]       recv_state, recv_state_next;
  logic [7:0]       endpoint_reg, endpoint_reg_next;
  logic [7:0]       xor_sum, xor_sum_next;
  logic [OFF_W-1:0] offset_count, offset_count_next;
  logic [OFF_W-1:0] end_offset, end_offset_next;
  logic [LEN_W-1:0] length_capture, length_capture_next;

  logic             in_xfer;
  logic             wake;
  logic             byte_valid;
  logic [OFF_W-1:0] byte_offset;
  logic [7:0]       byte_value;
  logic [1:0]       query_code;
  logic [9:0]       payload_length;

  logic [OFF_W-1:0] pos_plus;
  logic [OFF_W-1:0] lane;
  logic             lane_hit;
  logic [LEN_W-1:0] length_taken;
  logic [RES_W-1:0] result;

  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign cfg_ready     = !rst;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Byte store helpers: the length field is picked up from the bytes that
  // fall on its four little-endian positions.
  assign pos_plus = offset_count + OFF_W'(1);
  assign lane     = offset_count - OFF_W'(LENGTH_POS);
  assign lane_hit = (offset_count >= OFF_W'(LENGTH_POS)) && (lane < OFF_W'(4));
  assign length_taken = lane_hit
      ? (length_capture | (LEN_W'(s_axis_tdata) << {lane[1:0], 3'b000}))
      : length_capture;

  always_comb begin
    recv_state_next     = recv_state;
    endpoint_reg_next   = endpoint_reg;
    xor_sum_next        = xor_sum;
    offset_count_next   = offset_count;
    end_offset_next     = end_offset;
    length_capture_next = length_capture;
    wake                = 1'b0;
    byte_valid          = 1'b0;
    byte_offset         = '0;
    byte_value          = '0;

    if (s_axis_tuser == KIND_CLEAR) begin
      recv_state_next     = ST_IDLE;
      endpoint_reg_next   = '0;
      xor_sum_next        = '0;
      offset_count_next   = '0;
      end_offset_next     = '0;
      length_capture_next = '0;
    end else begin
      case (recv_state)
        ST_IDLE: begin
          if (s_axis_tdata == open_code) begin
            recv_state_next     = ST_ENDPOINT;
            endpoint_reg_next   = '0;
            xor_sum_next        = '0;
            offset_count_next   = '0;
            end_offset_next     = '0;
            length_capture_next = '0;
          end else begin
            recv_state_next = ST_ERROR;
            wake            = 1'b1;
          end
        end
        ST_ENDPOINT: begin
          xor_sum_next      = s_axis_tdata;
          endpoint_reg_next = s_axis_tdata;
          end_offset_next   = OFF_W'(HEADER_LEN);
          recv_state_next   = ST_HEADER;
        end
        ST_HEADER: begin
          xor_sum_next        = xor_sum ^ s_axis_tdata;
          length_capture_next = length_taken;
          offset_count_next   = pos_plus;
          byte_valid          = 1'b1;
          byte_offset         = offset_count;
          byte_value          = s_axis_tdata;
          if (pos_plus >= OFF_W'(HEADER_LEN)) begin
            if (length_taken > LEN_W'(MAX_PAYLOAD)) begin
              recv_state_next = ST_ERROR;
              wake            = 1'b1;
            end else if (length_taken != '0) begin
              end_offset_next = OFF_W'(HEADER_LEN) + length_taken[OFF_W-1:0];
              recv_state_next = ST_PAYLOAD;
            end else begin
              recv_state_next = ST_CHECKSUM;
            end
          end
        end
        ST_PAYLOAD: begin
          xor_sum_next        = xor_sum ^ s_axis_tdata;
          length_capture_next = length_taken;
          offset_count_next   = pos_plus;
          byte_valid          = 1'b1;
          byte_offset         = offset_count;
          byte_value          = s_axis_tdata;
          if (pos_plus >= end_offset) begin
            recv_state_next = ST_CHECKSUM;
          end
        end
        ST_CHECKSUM: begin
          xor_sum_next    = xor_sum ^ s_axis_tdata;
          recv_state_next = ((xor_sum ^ s_axis_tdata) == 8'h00) ? ST_READY : ST_ERROR;
          wake            = 1'b1;
        end
        ST_ERROR: begin
          recv_state_next = ST_ERROR;
        end
        default: begin
          // A byte after the frame is ready is a protocol error.
          recv_state_next = ST_ERROR;
          wake            = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    if (recv_state_next == ST_READY) begin
      query_code = Q_READY;
    end else if (recv_state_next == ST_ERROR) begin
      query_code = Q_ERROR;
    end else begin
      query_code = Q_NOTREADY;
    end
    if (offset_count_next >= OFF_W'(HEADER_LEN)
        && length_capture_next <= LEN_W'(MAX_PAYLOAD)) begin
      payload_length = length_capture_next[9:0];
    end else begin
      payload_length = '0;
    end
  end

  assign result = RES_W'({payload_length, endpoint_reg_next, byte_value,
                          10'(byte_offset), byte_valid, wake, query_code,
                          recv_state_next});

  always_ff @(posedge clk) begin
    if (rst) begin
      open_code      <= '0;
      recv_state     <= ST_IDLE;
      endpoint_reg   <= '0;
      xor_sum        <= '0;
      offset_count   <= '0;
      end_offset     <= '0;
      length_capture <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        open_code <= cfg_data;
      end
      if (in_xfer) begin
        recv_state     <= recv_state_next;
        endpoint_reg   <= endpoint_reg_next;
        xor_sum        <= xor_sum_next;
        offset_count   <= offset_count_next;
        end_offset     <= end_offset_next;
        length_capture <= length_capture_next;
        m_axis_tvalid  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_axis_tdata <= result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the serial frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfr_checker
  import sfr_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             s_axis_tuser,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [RES_W-1:0] m_axis_tdata
);

  logic [2:0] status;
  logic       wake;
  logic [9:0] payload_length;
  logic       in_xfer;

  assign status         = m_axis_tdata[2:0];
  assign wake           = m_axis_tdata[5];
  assign payload_length = m_axis_tdata[42:33];
  assign in_xfer        = s_axis_tvalid && s_axis_tready;

  // A waiting result must not change before it is transferred.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // A clear is answered in the next cycle with an idle result and no wake.
  `ASSERT_NEXT(a_clear_idle, clk, rst, in_xfer && (s_axis_tuser == KIND_CLEAR),
               m_axis_tvalid && (status == ST_IDLE) && !wake, "clear not reported as idle")

  // Wake is only raised on the transfer that ends a frame or raises an error.
  `ASSERT_SAME(a_wake_state, clk, rst, m_axis_tvalid && wake,
               (status == ST_READY) || (status == ST_ERROR), "wake outside ready or error")

  // A reported length never exceeds the largest payload.
  `ASSERT_SAME(a_len_bound, clk, rst, m_axis_tvalid,
               payload_length <= 10'(MAX_PAYLOAD), "payload length out of range")

endmodule

bind serial_frame_receiver_xor sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial frame receiver. Directed frames cover
// three error paths and the zero-length frame, then random frames, truncated
// frames and noise run under several start byte settings. Both stream sides
// idle at random, and every result transfer is checked against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  // Result word, lowest field last so that it lands in the low bits.
  typedef struct packed {
    logic [9:0] payload_length;
    logic [7:0] endpoint;
    logic [7:0] byte_value;
    logic [9:0] byte_offset;
    logic       byte_valid;
    logic       wake;
    logic [1:0] query_code;
    logic [2:0] status;
  } rx_result_t;

  class frame_scoreboard;
    logic [7:0]  start_code;
    logic [2:0]  rx_state;
    logic [7:0]  ep_reg;
    logic [7:0]  xor_acc;
    int          offset_now;
    int          offset_stop;
    logic [31:0] length_acc;
    rx_result_t  frame_results_due[$];
    int          errors;
    int          taken;
    int          results_seen;

    function new();
      start_code = 8'h00;
      clear_frame();
    endfunction

    function void clear_frame();
      rx_state    = ST_IDLE;
      ep_reg      = 8'h00;
      xor_acc     = 8'h00;
      offset_now  = 0;
      offset_stop = 0;
      length_acc  = '0;
    endfunction

    function void set_start(logic [7:0] value);
      start_code = value;
    endfunction

    function int pending();
      return frame_results_due.size();
    endfunction

    function void store_byte(logic [7:0] b, inout rx_result_t r);
      int pos;
      pos = offset_now;
      xor_acc ^= b;
      if (pos >= LENGTH_POS && pos - LENGTH_POS < 4)
        length_acc |= 32'(b) << (8 * (pos - LENGTH_POS));
      r.byte_valid  = 1'b1;
      r.byte_offset = 10'(pos);
      r.byte_value  = b;
      offset_now    = pos + 1;
    endfunction

    // Advance the receiver by one accepted input transfer.
    function void take_input(logic kind, logic [7:0] b);
      rx_result_t r;
      r = '0;
      taken++;
      if (kind == KIND_CLEAR) begin
        clear_frame();
      end else begin
        case (rx_state)
          ST_IDLE: begin
            if (b == start_code) begin
              clear_frame();
              rx_state = ST_ENDPOINT;
            end else begin
              rx_state = ST_ERROR;
              r.wake   = 1'b1;
            end
          end
          ST_ENDPOINT: begin
            xor_acc     = b;
            ep_reg      = b;
            offset_stop = HEADER_LEN;
            rx_state    = ST_HEADER;
          end
          ST_HEADER: begin
            store_byte(b, r);
            if (offset_now >= HEADER_LEN) begin
              if (length_acc > MAX_PAYLOAD) begin
                rx_state = ST_ERROR;
                r.wake   = 1'b1;
              end else if (length_acc != 0) begin
                offset_stop = HEADER_LEN + int'(length_acc);
                rx_state    = ST_PAYLOAD;
              end else begin
                rx_state = ST_CHECKSUM;
              end
            end
          end
          ST_PAYLOAD: begin
            store_byte(b, r);
            if (offset_now >= offset_stop)
              rx_state = ST_CHECKSUM;
          end
          ST_CHECKSUM: begin
            xor_acc ^= b;
            rx_state = (xor_acc == 8'h00) ? ST_READY : ST_ERROR;
            r.wake   = 1'b1;
          end
          ST_ERROR: begin
          end
          // A byte after a complete frame is an overrun.
          default: begin
            rx_state = ST_ERROR;
            r.wake   = 1'b1;
          end
        endcase
      end
      if (offset_now >= HEADER_LEN && length_acc <= MAX_PAYLOAD)
        r.payload_length = length_acc[9:0];
      r.status   = rx_state;
      r.endpoint = ep_reg;
      if (rx_state == ST_READY)
        r.query_code = Q_READY;
      else if (rx_state == ST_ERROR)
        r.query_code = Q_ERROR;
      else
        r.query_code = Q_NOTREADY;
      frame_results_due.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 200)
        $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                         results_seen, name, got, want));
    endtask

    task check_result(logic [RES_W-1:0] word);
      rx_result_t got;
      rx_result_t want;
      got = word[RES_BITS-1:0];
      results_seen++;
      if (frame_results_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results_seen));
        return;
      end
      want = frame_results_due.pop_front();
      cmp_field("status", got.status, want.status);
      cmp_field("query_code", got.query_code, want.query_code);
      cmp_field("wake", got.wake, want.wake);
      cmp_field("byte_valid", got.byte_valid, want.byte_valid);
      cmp_field("byte_offset", got.byte_offset, want.byte_offset);
      cmp_field("byte_value", got.byte_value, want.byte_value);
      cmp_field("endpoint", got.endpoint, want.endpoint);
      cmp_field("payload_length", got.payload_length, want.payload_length);
      cmp_field("fill", int'(word[RES_W-1:RES_BITS]), 0);
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = 8'h00;   // data_byte
  logic             s_axis_tuser = 1'b0;    // kind
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // status, query_code, wake, byte_valid, byte_offset, byte_value,
  // endpoint, payload_length, zero fill
  logic [RES_W-1:0] m_axis_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [7:0]       cfg_data = 8'h00;

  frame_scoreboard sb = new();
  logic [7:0]      start_now = 8'h00;
  int              gap_max   = 0;
  int              stall_max = 0;

  always #5 clk = ~clk;

  serial_frame_receiver_xor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Valid is left high after a transfer so that a following item with no gap
  // keeps it high rather than dropping and raising it in one step.
  task automatic push_item(input logic kind, input logic [7:0] value);
    int gap;
    gap = $urandom_range(gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_input(kind, value);
  endtask

  task automatic send_clear();
    push_item(KIND_CLEAR, 8'($urandom));
  endtask

  // A cut of zero or more sends at most that many leading bytes of the frame.
  task automatic send_frame(input logic [31:0] len_field, input logic [7:0] sum_flip,
                            input int cut);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    logic [7:0] hb;
    int         body;
    int         pos;
    int         count;
    body = (len_field <= MAX_PAYLOAD) ? int'(len_field) : 0;
    hb = 8'($urandom);
    frame_bytes.push_back(start_now);
    frame_bytes.push_back(hb);
    sum = hb;
    for (int i = 0; i < HEADER_LEN; i++) begin
      pos = i - LENGTH_POS;
      hb  = (pos >= 0 && pos < 4) ? 8'(len_field >> (8 * pos)) : 8'($urandom);
      frame_bytes.push_back(hb);
      sum ^= hb;
    end
    for (int i = 0; i < body; i++) begin
      hb = 8'($urandom);
      frame_bytes.push_back(hb);
      sum ^= hb;
    end
    frame_bytes.push_back(sum ^ sum_flip);
    count = (cut >= 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
    for (int i = 0; i < count; i++)
      push_item(KIND_BYTE, frame_bytes[i]);
  endtask

  task automatic random_traffic(input int amount);
    int          target;
    int          pick;
    int          cut;
    logic [31:0] len_field;
    logic [7:0]  flip;
    target = sb.taken + amount;
    while (sb.taken < target) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        pick = $urandom_range(99);
        if (pick < 10)
          len_field = 0;
        else if (pick < 60)
          len_field = $urandom_range(16, 1);
        else if (pick < 84)
          len_field = $urandom_range(64, 17);
        else if (pick < 86)
          len_field = MAX_PAYLOAD;
        else if (pick < 88)
          len_field = $urandom_range(MAX_PAYLOAD - 1, MAX_PAYLOAD - 12);
        else if (pick < 91)
          len_field = MAX_PAYLOAD + 1;
        else begin
          len_field = $urandom;
          if (len_field <= MAX_PAYLOAD)
            len_field += MAX_PAYLOAD + 1;
        end
        flip = ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom_range(255, 1));
        cut  = ($urandom_range(99) < 5) ? $urandom_range(HEADER_LEN + 1, 1) : -1;
        send_frame(len_field, flip, cut);
        // Mostly tidy up after the frame; sometimes overrun it first or
        // leave the next frame to collide with whatever state is left.
        pick = $urandom_range(9);
        if (pick < 7) begin
          send_clear();
        end else if (pick < 8) begin
          push_item(KIND_BYTE, 8'($urandom));
          send_clear();
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(4) == 0)
            send_clear();
          else
            push_item(KIND_BYTE, 8'($urandom));
        end
      end else begin
        send_clear();
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_open_code(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_start(value);
    start_now = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(stall_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the start byte still at its reset value.
    gap_max   = 3;
    stall_max = 3;
    push_item(KIND_BYTE, 8'h5A);           // not a start byte while idle
    push_item(KIND_BYTE, 8'hFF);           // dropped while in error
    push_item(KIND_CLEAR, 8'hFF);
    send_frame(32'd0, 8'h00, -1);          // zero length, good checksum
    push_item(KIND_BYTE, 8'h00);           // overrun after a complete frame
    push_item(KIND_CLEAR, 8'h00);
    send_frame(32'hFFFF_FFFF, 8'h00, HEADER_LEN + 2);  // oversized length
    push_item(KIND_CLEAR, 8'h55);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_open_code(8'hFF);
          gap_max   = 17;
          stall_max = 17;
        end
        1: begin
          set_open_code(8'h00);
          gap_max   = 0;
          stall_max = 0;
        end
        2: begin
          set_open_code(8'($urandom_range(254, 1)));
          gap_max   = 17;
          stall_max = 2;
        end
        default: begin
          set_open_code(8'($urandom));
          gap_max   = 2;
          stall_max = 17;
        end
      endcase
      random_traffic(355);
      drain();
    end

    repeat (5) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
